FILE: src/aadp_pkg.sv
`default_nettype none

package aadp_pkg;

  // Largest number of AU sizes held per packet
  localparam int unsigned MaxAu = 16;

  // Configuration register indexes
  localparam logic [1:0] CfgMinLen  = 2'd0;
  localparam logic [1:0] CfgAdtsTwo = 2'd1;
  localparam logic [1:0] CfgAdtsThr = 2'd2;

  // Configuration reset values
  localparam logic [15:0] MinLenReset  = 16'd100;
  localparam logic [7:0]  AdtsTwoReset = 8'h50;
  localparam logic [7:0]  AdtsThrReset = 8'h80;

  // Results that one input item causes, handed from parser to emitter
  typedef struct packed {
    logic        hdr;       // seven ADTS header bytes come first
    logic [12:0] len;       // ADTS frame length, saturated
    logic        data_vld;  // one payload byte follows
    logic [7:0]  data;
    logic        eof;       // payload byte closes the frame
    logic        status;    // packet error item comes last
  } burst_t;

endpackage

`default_nettype wire

FILE: src/aadp_parser.sv
`default_nettype none

module aadp_parser #(
  parameter int unsigned MAX_AU = aadp_pkg::MaxAu
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 first_i,
  input  wire logic                 last_i,
  input  wire logic [15:0]          plen_i,
  input  wire logic [15:0]          min_len_i,
  output aadp_pkg::burst_t          burst_o
);

  localparam int unsigned IdxW = (MAX_AU > 1) ? $clog2(MAX_AU) : 1;

  typedef enum logic [7:0] {
    PhIdle   = 8'b0000_0001,
    PhRtp    = 8'b0000_0010,
    PhLenHi  = 8'b0000_0100,
    PhLenLo  = 8'b0000_1000,
    PhSizes  = 8'b0001_0000,
    PhPend   = 8'b0010_0000,
    PhStream = 8'b0100_0000,
    PhTail   = 8'b1000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] left_q, left_d;
  logic [3:0]  total_q, total_d;
  logic [3:0]  cursor_q, cursor_d;
  logic [12:0] remain_q, remain_d;
  logic [7:0]  hi_q, hi_d;
  logic        bad_q, bad_d;
  logic [MAX_AU-1:0] mask_q, mask_d;

  logic [12:0] table_q [MAX_AU];

  logic            tbl_we;
  logic [IdxW-1:0] tbl_widx;
  logic [12:0]     tbl_wval;

  // First set mask bit at or after s and below k; k when there is none
  function automatic logic [4:0] find_next(logic [MAX_AU-1:0] m, logic [4:0] s,
                                           logic [4:0] k);
    logic [4:0] r;
    r = k;
    for (int i = MAX_AU - 1; i >= 0; i--) begin
      if (m[i] && (5'(i) >= s) && (5'(i) < k)) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

  always_comb begin
    phase_e      ph;
    logic [15:0] off;
    logic [14:0] idx;
    logic [12:0] size;
    logic [13:0] lsum;
    logic [4:0]  kcnt;
    logic [4:0]  nxt;
    logic        adv;
    logic [4:0]  adv_start;

    // Start-of-packet values override the held state
    ph        = first_i ? ((plen_i <= min_len_i) ? PhTail : PhRtp) : phase_q;
    pos_d     = first_i ? 16'd0 : pos_q;
    left_d    = first_i ? plen_i : left_q;
    total_d   = first_i ? 4'd0 : total_q;
    cursor_d  = first_i ? 4'd0 : cursor_q;
    remain_d  = first_i ? 13'd0 : remain_q;
    hi_d      = first_i ? 8'd0 : hi_q;
    bad_d     = first_i ? 1'b0 : bad_q;
    phase_d   = ph;
    mask_d    = mask_q;
    burst_o   = '0;
    tbl_we    = 1'b0;
    tbl_widx  = '0;
    tbl_wval  = {hi_d, byte_i[7:3]};
    adv       = 1'b0;
    adv_start = 5'd0;
    off       = pos_d - 16'd14;
    idx       = off[15:1];
    size      = table_q[cursor_d[IdxW-1:0]];
    lsum      = {1'b0, size} + 14'd7;

    unique case (ph)
      PhRtp: begin
        if (pos_d >= 16'd11) begin
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        phase_d = (byte_i != 8'd0) ? PhTail : PhLenLo;
      end
      PhLenLo: begin
        total_d = byte_i[7:4];
        if (total_d == 4'd0) begin
          phase_d = PhTail;
        end else if (left_d < (16'd1 + {11'd0, total_d, 1'b0})) begin
          bad_d   = 1'b1;
          phase_d = PhTail;
        end else begin
          phase_d = PhSizes;
        end
      end
      PhSizes: begin
        if (!off[0]) begin
          hi_d = byte_i;
        end else begin
          if ({1'b0, idx} < 16'(MAX_AU)) begin
            tbl_we   = 1'b1;
            tbl_widx = idx[IdxW-1:0];
            mask_d[idx[IdxW-1:0]] = (tbl_wval != 13'd0);
          end
          if (({1'b0, idx} + 16'd1) >= {12'd0, total_d}) begin
            cursor_d  = 4'd0;
            adv       = 1'b1;
            adv_start = 5'd0;
          end
        end
      end
      PhPend: begin
        if (({3'd0, size} > left_d) || (last_i && (size > 13'd1))) begin
          bad_d   = 1'b1;
          phase_d = PhTail;
        end else begin
          burst_o.hdr      = 1'b1;
          burst_o.len      = lsum[13] ? 13'h1FFF : lsum[12:0];
          burst_o.data_vld = 1'b1;
          burst_o.data     = byte_i;
          remain_d         = size - 13'd1;
          if (remain_d == 13'd0) begin
            burst_o.eof = 1'b1;
            adv         = 1'b1;
            adv_start   = {1'b0, cursor_d} + 5'd1;
          end else begin
            phase_d = PhStream;
          end
        end
      end
      PhStream: begin
        remain_d         = remain_d - 13'd1;
        burst_o.data_vld = 1'b1;
        burst_o.data     = byte_i;
        if (remain_d == 13'd0) begin
          burst_o.eof = 1'b1;
          adv         = 1'b1;
          adv_start   = {1'b0, cursor_d} + 5'd1;
        end
      end
      default: begin
      end
    endcase

    // Skip empty AUs; the count is capped by the table depth
    kcnt = ({1'b0, total_d} < 5'(MAX_AU)) ? {1'b0, total_d} : 5'(MAX_AU);
    nxt  = find_next(mask_d, adv_start, kcnt);
    if (adv) begin
      cursor_d = nxt[3:0];
      phase_d  = (nxt < kcnt) ? PhPend : PhTail;
    end

    if (ph != PhIdle) begin
      if (pos_d != 16'hFFFF) begin
        pos_d = pos_d + 16'd1;
      end
      if (left_d != 16'd0) begin
        left_d = left_d - 16'd1;
      end
      if (last_i) begin
        if ((phase_d != PhIdle) && (phase_d != PhTail)) begin
          bad_d = 1'b1;
        end
        burst_o.status = bad_d;
        bad_d          = 1'b0;
        phase_d        = PhIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      pos_q    <= '0;
      left_q   <= '0;
      total_q  <= '0;
      cursor_q <= '0;
      remain_q <= '0;
      hi_q     <= '0;
      bad_q    <= 1'b0;
      mask_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      left_q   <= left_d;
      total_q  <= total_d;
      cursor_q <= cursor_d;
      remain_q <= remain_d;
      hi_q     <= hi_d;
      bad_q    <= bad_d;
      mask_q   <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && tbl_we) begin
      table_q[tbl_widx] <= tbl_wval;
    end
  end

endmodule

`default_nettype wire

FILE: src/aadp_emitter.sv
`default_nettype none

module aadp_emitter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire aadp_pkg::burst_t  burst_i,
  input  wire logic [7:0]        adts_two_i,
  input  wire logic [7:0]        adts_thr_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_hdr_o,
  output logic                   out_eof_o,
  output logic                   out_err_o
);

  localparam int unsigned Slots   = 9;
  localparam int unsigned DataBit = 7;
  localparam int unsigned StatBit = 8;

  // Pending result slots: header bytes 0..6, payload byte, status item
  logic [Slots-1:0] pend_q, pend_d;
  logic [Slots-1:0] cur;
  logic [12:0]      len_q;
  logic [7:0]       data_q;
  logic             eof_q;
  logic [2:0]       hidx;
  logic             out_fire;

  function automatic logic [7:0] adts_byte(logic [2:0] i, logic [12:0] len,
                                           logic [7:0] b2, logic [7:0] b3);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'hFF;
      3'd1:    r = 8'hF9;
      3'd2:    r = b2;
      3'd3:    r = (b3 & 8'hFC) | {6'd0, len[12:11]};
      3'd4:    r = len[10:3];
      3'd5:    r = {len[2:0], 5'h1F};
      3'd6:    r = 8'hFC;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign cur         = pend_q & (~pend_q + 9'd1);
  assign out_valid_o = (pend_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (pend_q == '0) || ($onehot(pend_q) && out_ready_i);

  always_comb begin
    hidx = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (cur[i]) begin
        hidx = 3'(i);
      end
    end
  end

  assign out_hdr_o  = (cur[6:0] != 7'd0);
  assign out_err_o  = cur[StatBit];
  assign out_eof_o  = cur[DataBit] && eof_q;
  assign out_byte_o = out_hdr_o ? adts_byte(hidx, len_q, adts_two_i, adts_thr_i)
                    : (cur[DataBit] ? data_q : 8'h00);

  always_comb begin
    if (accept_i) begin
      pend_d = {burst_i.status, burst_i.data_vld, {7{burst_i.hdr}}};
    end else if (out_fire) begin
      pend_d = pend_q & ~cur;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      len_q  <= burst_i.len;
      data_q <= burst_i.data;
      eof_q  <= burst_i.eof;
    end
  end

  a_no_accept_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(pend_q) > 1) |-> !in_ready_o)
    else $error("item taken while a burst still has several results");

  a_hdr_not_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_hdr_o) |-> (!out_eof_o && !out_err_o))
    else $error("header byte flagged as frame end or status");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_err_o) |-> (out_byte_o == 8'h00 && !out_eof_o))
    else $error("status item carries data");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cur)))
    else $error("pending slot changed under back-pressure");

endmodule

`default_nettype wire

FILE: src/aac_rtp_to_adts_depacketizer.sv
`default_nettype none

// AAC over RTP (high-bit-rate AU headers) to ADTS converter. Feed the UDP
// payload one byte per item, first byte marked in s_axis_tuser with the
// packet length in the upper bits of s_axis_tdata, last byte marked by
// s_axis_tlast. Packets whose declared length does not exceed
// min_packet_length, or whose byte 12 is nonzero, are dropped. Each AU of a
// packet leaves as its own ADTS frame: seven header bytes (tuser bit 0 set)
// and the payload, tlast on the last payload byte. A packet that ends early
// or whose AU overruns it gets one status item (tuser bit 1) after its last
// byte's results. One byte is taken per cycle while each yields one result
// and m_axis_tready is high; an AU's first byte adds seven header bytes and
// a status item one more result, all via the single output byte lane. A new
// byte is taken while the previous one's last result is being delivered.
// Up to MAX_AU AU sizes are held per packet; no clearing pass follows reset.

module aac_rtp_to_adts_depacketizer #(
  parameter int unsigned MAX_AU = aadp_pkg::MaxAu
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // in_byte [7:0], packet_length [23:8]
  input  wire logic        s_axis_tlast,  // last_of_packet
  input  wire logic        s_axis_tuser,  // first_of_packet
  // ADTS output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte [7:0]
  output logic             m_axis_tlast,  // end_of_frame
  output logic [1:0]       m_axis_tuser,  // is_header_byte [0], packet_error [1]
  // Configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] min_len_q;
  logic [7:0]  adts_two_q;
  logic [7:0]  adts_thr_q;

  logic             in_accept;
  aadp_pkg::burst_t burst;

  // Hold configuration; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= aadp_pkg::MinLenReset;
      adts_two_q <= aadp_pkg::AdtsTwoReset;
      adts_thr_q <= aadp_pkg::AdtsThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aadp_pkg::CfgMinLen:  min_len_q  <= cfg_data_i;
        aadp_pkg::CfgAdtsTwo: adts_two_q <= cfg_data_i[7:0];
        aadp_pkg::CfgAdtsThr: adts_thr_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Parse one byte per accepted item and work out the results it causes
  aadp_parser #(
    .MAX_AU (MAX_AU)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .byte_i    (s_axis_tdata[7:0]),
    .first_i   (s_axis_tuser),
    .last_i    (s_axis_tlast),
    .plen_i    (s_axis_tdata[23:8]),
    .min_len_i (min_len_q),
    .burst_o   (burst)
  );

  // Register the results and send them out one byte at a time
  aadp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .burst_i     (burst),
    .adts_two_i  (adts_two_q),
    .adts_thr_i  (adts_thr_q),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_hdr_o   (m_axis_tuser[0]),
    .out_eof_o   (m_axis_tlast),
    .out_err_o   (m_axis_tuser[1])
  );

endmodule

`default_nettype wire
